// ===== design/sea_ice_freeze_melt_step_unit_assert.svh =====
// Assertion macros used by the checker file of the freeze and melt step unit.
`ifndef SEA_ICE_FREEZE_MELT_STEP_UNIT_ASSERT_SVH
`define SEA_ICE_FREEZE_MELT_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SFM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("freeze melt step check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SFM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("freeze melt step check failed");

`endif

// ===== design/sfm_pkg.sv =====
`default_nettype none

package sfm_pkg;

    typedef logic signed [63:0] t_s64;

    localparam int MUL_LAT   = 5;
    localparam int DIV_STEPS = 96;
    localparam int DVD_W     = 96;
    localparam int DIV_LAT   = DIV_STEPS + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    localparam t_s64 Q_ONE = 64'sh0000_0001_0000_0000;
    localparam t_s64 Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 Q_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_H0,
        REG_DT,
        REG_CMIN,
        REG_HMIN,
        REG_LFI,
        REG_LFW,
        REG_RHOI,
        REG_RHOS
    } t_reg_idx;

    typedef struct packed {
        t_s64        open_water_flux;
        logic [62:0] heat_capacity;
        t_s64        surface_temp;
        t_s64        freezing_temp;
        logic [32:0] concentration;
        logic [62:0] ice_volume;
        logic [62:0] snow_volume;
        t_s64        thickness_change;
    } t_sfm_in;

    typedef struct packed {
        t_s64        flux_out;
        logic [62:0] new_ice;
        logic [62:0] concentration_out;
        logic [62:0] ice_volume_out;
        logic [62:0] snow_volume_out;
        t_s64        concentration_change;
        logic        cleared;
        t_s64        removed_ice;
        t_s64        removed_snow;
    } t_sfm_out;

    function automatic t_s64 sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 sat_sub(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 sat_neg(input t_s64 a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    function automatic logic [63:0] mag(input t_s64 a);
        logic [63:0] u;
        u = a;
        return a[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic t_s64 from_mag(input logic neg, input logic over,
                                      input logic [63:0] m);
        if (neg) begin
            if (over || m[63]) return Q_MIN;
            return $signed(~m + 64'd1);
        end
        if (over || m[63]) return Q_MAX;
        return $signed(m);
    endfunction

    function automatic logic [62:0] u63(input t_s64 x);
        return x[63] ? 63'd0 : x[62:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/sfm_dly.sv =====
`default_nettype none

module sfm_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [D];

    // Shift the side data along with the arithmetic units
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[D-1];

endmodule

`default_nettype wire

// ===== design/sfm_mul.sv =====
`default_nettype none

module sfm_mul import sfm_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_s64 i_a,
    input  t_s64 i_b,
    output t_s64 o_p
);

    t_s64         r_a, r_b;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg2, r_neg3, r_neg4;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_prod;
    t_s64         r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // capture operands
            r_a    <= i_a;
            r_b    <= i_b;
            // take magnitudes
            r_ma   <= mag(r_a);
            r_mb   <= mag(r_b);
            r_neg2 <= r_a[63] ^ r_b[63];
            // four 32x32 partial products
            r_p00  <= {32'd0, r_ma[31:0]}  * {32'd0, r_mb[31:0]};
            r_p01  <= {32'd0, r_ma[31:0]}  * {32'd0, r_mb[63:32]};
            r_p10  <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[31:0]};
            r_p11  <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[63:32]};
            r_neg3 <= r_neg2;
            // combine into the full product
            r_prod <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                      + {r_p11, 64'd0};
            r_neg4 <= r_neg3;
            // drop the fraction, saturate
            r_p    <= from_mag(r_neg4, r_prod[127:96] != 32'd0, r_prod[95:32]);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== design/sfm_div.sv =====
`default_nettype none

module sfm_div import sfm_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_s64 i_a,
    input  t_s64 i_b,
    output t_s64 o_q
);

    t_s64             r_a, r_b;
    logic [DVD_W-1:0] r_dvd [DIV_STEPS+1];
    logic [63:0]      r_rem [DIV_STEPS+1];
    logic [63:0]      r_quo [DIV_STEPS+1];
    logic [63:0]      r_nb  [DIV_STEPS+1];
    logic             r_ovf [DIV_STEPS+1];
    logic             r_neg [DIV_STEPS+1];
    logic             r_bz  [DIV_STEPS+1];
    t_s64             r_q;

    // Capture operands, then set up magnitudes and the shifted dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_dvd[0] <= {mag(r_a), 32'd0};
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_nb[0]  <= mag(r_b);
            r_ovf[0] <= 1'b0;
            r_neg[0] <= r_a[63] ^ r_b[63];
            r_bz[0]  <= (r_b == '0);
        end
    end

    // One restoring step per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [64:0] w_sh;
        logic [65:0] w_df;

        assign w_sh = {r_rem[k], r_dvd[k][DVD_W-1]};
        assign w_df = {1'b0, w_sh} - {2'b00, r_nb[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_df[65] ? w_sh[63:0] : w_df[63:0];
                r_quo[k+1] <= {r_quo[k][62:0], ~w_df[65]};
                r_ovf[k+1] <= r_ovf[k] | r_quo[k][63];
                r_dvd[k+1] <= {r_dvd[k][DVD_W-2:0], 1'b0};
                r_nb[k+1]  <= r_nb[k];
                r_neg[k+1] <= r_neg[k];
                r_bz[k+1]  <= r_bz[k];
            end
        end
    end

    // Apply sign and saturation, zero for a zero divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_bz[DIV_STEPS] ? '0
                 : from_mag(r_neg[DIV_STEPS], r_ovf[DIV_STEPS], r_quo[DIV_STEPS]);
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== design/sea_ice_freeze_melt_step_unit.sv =====
// Freeze and melt step for one sea-ice grid cell per transfer.
// Input channel: i_in_valid / o_in_ready carry one cell (t_sfm_in). Output channel:
// o_out_valid / i_out_ready carry its result (t_sfm_out), exactly one per cell, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx on the same edge;
// write only while no cell is in flight.
// Depth: 526 register stages: five pipelined dividers of 99 stages each (one quotient bit
// per stage) and six 5-stage multipliers, chained, plus the output register.
// Throughput: one cell per cycle. The whole pipeline advances together whenever the
// output register is empty or being taken, so the rate is set by the output stage.
// Receiver stall: while o_out_valid is high and i_out_ready low, every stage holds and
// o_in_ready is low; nothing is dropped or repeated.
// Reset (synchronous, active low): clears all stage valid bits and loads the register
// defaults; the first cell may be offered on the cycle after reset is released.
`default_nettype none

module sea_ice_freeze_melt_step_unit import sfm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_sfm_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_sfm_out              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NST = 5 * DIV_LAT + 6 * MUL_LAT + 1;

    typedef struct packed {
        t_s64        q, t0, tf, dhi;
        logic [32:0] c;
        logic [62:0] h, hs;
    } t_b1;

    typedef struct packed {
        t_s64        q, t0, tf, dhi;
        logic [32:0] c;
        logic [62:0] h, hs;
        t_s64        hq, slice;
    } t_b2;

    typedef struct packed {
        t_s64        q;
        logic [32:0] c;
        logic [62:0] h, hs;
        logic        below, cond;
        t_s64        slice;
    } t_b3;

    typedef struct packed {
        t_s64        q;
        logic [32:0] c;
        logic [62:0] h, hs;
        logic        below;
        t_s64        dcm;
    } t_b4;

    typedef struct packed {
        t_s64        q1;
        logic [32:0] c;
        logic [62:0] h;
        t_s64        hs2;
        logic        below;
        t_s64        dcm;
    } t_b5;

    typedef struct packed {
        t_s64        q2;
        logic [32:0] c;
        logic [62:0] h;
        t_s64        hs2, dcm, newice;
    } t_b8;

    typedef struct packed {
        t_s64 q2, c2, h2, hs2, dc, newice;
    } t_b9;

    typedef struct packed {
        t_s64 q2, c2, h2, hs2, dc, newice;
        logic clr;
    } t_b10;

    // Configuration registers
    logic [62:0] r_h0, r_dt, r_hmin, r_lfi, r_lfw, r_rhoi, r_rhos;
    logic [32:0] r_cmin;
    t_s64        w_h0, w_dt, w_cmin, w_hmin, w_lfi, w_lfw, w_rhoi, w_rhos, w_lr;

    logic [NST-1:0] r_vld;
    logic           w_en;
    t_sfm_out       r_out, n_out;

    // Stage signals
    t_b1  w_b1_in, w_b1_out;
    t_b2  w_b2_in, w_b2_out;
    t_b3  w_b3_in, w_b3_out;
    t_b4  w_b4_in, w_b4_out;
    t_b5  w_b5_in, w_b5_out, w_b6_out, w_b7_out;
    t_b8  w_b8_in, w_b8_out;
    t_b9  w_b9_in, w_b9_out;
    t_b10 w_b10_in, w_b10_out, w_b11_out;
    t_s64 w_cdiv, w_d1, w_d2, w_d3, w_dtml, w_m1, w_d4, w_d5, w_sens, w_ms1;
    t_s64 w_l1, w_ms2, w_l2, w_ms3, w_d6, w_d7, w_d8, w_hr, w_sr, w_e, w_d9;
    t_s64 w_hiold, w_dcm, w_dc;

    // Load register defaults, take writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0   <= 63'd1073741824;
            r_dt   <= 63'd2576980377600;
            r_cmin <= 33'd1;
            r_hmin <= 63'd42949673;
            r_lfi  <= 63'd1432586341580800;
            r_lfw  <= 63'd1432586341580800;
            r_rhoi <= 63'd3938485010432;
            r_rhos <= 63'd1417339207680;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_H0:   r_h0   <= i_cfg_data;
                REG_DT:   r_dt   <= i_cfg_data;
                REG_CMIN: r_cmin <= i_cfg_data[32:0];
                REG_HMIN: r_hmin <= i_cfg_data;
                REG_LFI:  r_lfi  <= i_cfg_data;
                REG_LFW:  r_lfw  <= i_cfg_data;
                REG_RHOI: r_rhoi <= i_cfg_data;
                REG_RHOS: r_rhos <= i_cfg_data;
                default:  r_h0   <= r_h0;
            endcase
        end
    end

    assign w_h0   = {1'b0, r_h0};
    assign w_dt   = {1'b0, r_dt};
    assign w_cmin = {31'd0, r_cmin};
    assign w_hmin = {1'b0, r_hmin};
    assign w_lfi  = {1'b0, r_lfi};
    assign w_lfw  = {1'b0, r_lfw};
    assign w_rhoi = {1'b0, r_rhoi};
    assign w_rhos = {1'b0, r_rhos};

    // Latent heat per unit volume of ice; settles long before any cell needs it
    sfm_mul u_mul_lr (.i_clk, .i_en(1'b1), .i_a(w_lfi), .i_b(w_rhoi), .o_p(w_lr));

    // Advance the pipeline when the output register is empty or being taken
    assign w_en        = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NST-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Phase 1: cooling quotient, mean thickness, snow slice
    always_comb begin
        w_b1_in.q   = i_in_data.open_water_flux;
        w_b1_in.t0  = i_in_data.surface_temp;
        w_b1_in.tf  = i_in_data.freezing_temp;
        w_b1_in.dhi = i_in_data.thickness_change;
        w_b1_in.c   = i_in_data.concentration;
        w_b1_in.h   = i_in_data.ice_volume;
        w_b1_in.hs  = i_in_data.snow_volume;
    end
    assign w_cdiv = (w_cmin > {31'd0, i_in_data.concentration}) ? w_cmin
                  : {31'd0, i_in_data.concentration};

    sfm_div u_div_cool (.i_clk, .i_en(w_en), .i_a(sat_neg(i_in_data.open_water_flux)),
                        .i_b({1'b0, i_in_data.heat_capacity}), .o_q(w_d1));
    sfm_div u_div_hq   (.i_clk, .i_en(w_en), .i_a({1'b0, i_in_data.ice_volume}),
                        .i_b({31'd0, i_in_data.concentration}), .o_q(w_d2));
    sfm_div u_div_slc  (.i_clk, .i_en(w_en), .i_a({1'b0, i_in_data.snow_volume}),
                        .i_b(w_cdiv), .o_q(w_d3));
    sfm_dly #(.W($bits(t_b1)), .D(DIV_LAT)) u_dly1 (.i_clk, .i_en(w_en),
                        .i_d(w_b1_in), .o_q(w_b1_out));

    // Phase 2: mixed-layer temperature change, melt numerator
    always_comb begin
        w_b2_in.q     = w_b1_out.q;
        w_b2_in.t0    = w_b1_out.t0;
        w_b2_in.tf    = w_b1_out.tf;
        w_b2_in.dhi   = w_b1_out.dhi;
        w_b2_in.c     = w_b1_out.c;
        w_b2_in.h     = w_b1_out.h;
        w_b2_in.hs    = w_b1_out.hs;
        w_b2_in.hq    = w_d2;
        w_b2_in.slice = w_d3;
    end
    sfm_mul u_mul_dtml (.i_clk, .i_en(w_en), .i_a(w_d1), .i_b(w_dt), .o_p(w_dtml));
    sfm_mul u_mul_m1   (.i_clk, .i_en(w_en), .i_a(w_b1_out.dhi),
                        .i_b({31'd0, w_b1_out.c}), .o_p(w_m1));
    sfm_dly #(.W($bits(t_b2)), .D(MUL_LAT)) u_dly2 (.i_clk, .i_en(w_en),
                        .i_d(w_b2_in), .o_q(w_b2_out));

    // Phase 3: sensible fraction and lateral melt rate
    assign w_hiold = sat_sub(w_b2_out.hq, w_b2_out.dhi);
    always_comb begin
        w_b3_in.q     = w_b2_out.q;
        w_b3_in.c     = w_b2_out.c;
        w_b3_in.h     = w_b2_out.h;
        w_b3_in.hs    = w_b2_out.hs;
        w_b3_in.below = sat_add(w_b2_out.t0, w_dtml) < w_b2_out.tf;
        w_b3_in.cond  = w_b2_out.dhi[63] && (w_b2_out.c != '0) && !w_b2_out.c[32];
        w_b3_in.slice = w_b2_out.slice;
    end
    sfm_div u_div_sens (.i_clk, .i_en(w_en), .i_a(sat_sub(w_b2_out.tf, w_b2_out.t0)),
                        .i_b(w_dtml), .o_q(w_d4));
    sfm_div u_div_dcm  (.i_clk, .i_en(w_en), .i_a(w_m1), .i_b(sat_add(w_hiold, w_hiold)),
                        .o_q(w_d5));
    sfm_dly #(.W($bits(t_b3)), .D(DIV_LAT)) u_dly3 (.i_clk, .i_en(w_en),
                        .i_d(w_b3_in), .o_q(w_b3_out));

    // Phase 4: sensible flux, snow slice change
    assign w_dcm = w_b3_out.cond ? w_d5 : '0;
    always_comb begin
        w_b4_in.q     = w_b3_out.q;
        w_b4_in.c     = w_b3_out.c;
        w_b4_in.h     = w_b3_out.h;
        w_b4_in.hs    = w_b3_out.hs;
        w_b4_in.below = w_b3_out.below;
        w_b4_in.dcm   = w_dcm;
    end
    sfm_mul u_mul_sens (.i_clk, .i_en(w_en), .i_a(w_d4), .i_b(w_b3_out.q), .o_p(w_sens));
    sfm_mul u_mul_ms1  (.i_clk, .i_en(w_en), .i_a(w_dcm), .i_b(w_b3_out.slice),
                        .o_p(w_ms1));
    sfm_dly #(.W($bits(t_b4)), .D(MUL_LAT)) u_dly4 (.i_clk, .i_en(w_en),
                        .i_d(w_b4_in), .o_q(w_b4_out));

    // Phase 5: latent heat times timestep, snow heat
    always_comb begin
        w_b5_in.q1    = w_b4_out.below ? w_sens : w_b4_out.q;
        w_b5_in.c     = w_b4_out.c;
        w_b5_in.h     = w_b4_out.h;
        w_b5_in.hs2   = sat_add({1'b0, w_b4_out.hs}, w_ms1);
        w_b5_in.below = w_b4_out.below;
        w_b5_in.dcm   = w_b4_out.dcm;
    end
    sfm_mul u_mul_l1  (.i_clk, .i_en(w_en), .i_a(sat_sub(w_b4_out.q, w_sens)),
                       .i_b(w_dt), .o_p(w_l1));
    sfm_mul u_mul_ms2 (.i_clk, .i_en(w_en), .i_a(w_ms1), .i_b(w_lfw), .o_p(w_ms2));
    sfm_dly #(.W($bits(t_b5)), .D(MUL_LAT)) u_dly5 (.i_clk, .i_en(w_en),
                       .i_d(w_b5_in), .o_q(w_b5_out));

    // Phase 6: scale by open-water fraction and snow density
    sfm_mul u_mul_l2  (.i_clk, .i_en(w_en), .i_a(w_l1),
                       .i_b(sat_sub(Q_ONE, {31'd0, w_b5_out.c})), .o_p(w_l2));
    sfm_mul u_mul_ms3 (.i_clk, .i_en(w_en), .i_a(w_ms2), .i_b(w_rhos), .o_p(w_ms3));
    sfm_dly #(.W($bits(t_b5)), .D(MUL_LAT)) u_dly6 (.i_clk, .i_en(w_en),
                       .i_d(w_b5_out), .o_q(w_b6_out));

    // Phase 7: new ice thickness, snow melt flux
    sfm_div u_div_ni  (.i_clk, .i_en(w_en), .i_a(w_l2), .i_b(w_lr), .o_q(w_d6));
    sfm_div u_div_sm  (.i_clk, .i_en(w_en), .i_a(w_ms3), .i_b(w_dt), .o_q(w_d7));
    sfm_dly #(.W($bits(t_b5)), .D(DIV_LAT)) u_dly7 (.i_clk, .i_en(w_en),
                       .i_d(w_b6_out), .o_q(w_b7_out));

    // Phase 8: spread new ice over h0
    always_comb begin
        w_b8_in.q2     = sat_sub(w_b7_out.q1, w_d7);
        w_b8_in.c      = w_b7_out.c;
        w_b8_in.h      = w_b7_out.h;
        w_b8_in.hs2    = w_b7_out.hs2;
        w_b8_in.dcm    = w_b7_out.dcm;
        w_b8_in.newice = (w_b7_out.below && !w_d6[63]) ? w_d6 : '0;
    end
    sfm_div u_div_dcf (.i_clk, .i_en(w_en), .i_a(w_b8_in.newice), .i_b(w_h0), .o_q(w_d8));
    sfm_dly #(.W($bits(t_b8)), .D(DIV_LAT)) u_dly8 (.i_clk, .i_en(w_en),
                       .i_d(w_b8_in), .o_q(w_b8_out));

    // Phase 9: update state, heat content of what remains
    assign w_dc = sat_add(w_d8, w_b8_out.dcm);
    always_comb begin
        w_b9_in.q2     = w_b8_out.q2;
        w_b9_in.c2     = sat_add({31'd0, w_b8_out.c}, w_dc);
        w_b9_in.h2     = sat_add({1'b0, w_b8_out.h}, w_b8_out.newice);
        w_b9_in.hs2    = w_b8_out.hs2;
        w_b9_in.dc     = w_dc;
        w_b9_in.newice = w_b8_out.newice;
    end
    sfm_mul u_mul_hr (.i_clk, .i_en(w_en), .i_a(w_b9_in.h2), .i_b(w_rhoi), .o_p(w_hr));
    sfm_mul u_mul_sr (.i_clk, .i_en(w_en), .i_a(w_b8_out.hs2), .i_b(w_rhos), .o_p(w_sr));
    sfm_dly #(.W($bits(t_b9)), .D(MUL_LAT)) u_dly9 (.i_clk, .i_en(w_en),
                       .i_d(w_b9_in), .o_q(w_b9_out));

    // Phase 10: clear test, latent heat of the cell contents
    always_comb begin
        w_b10_in.q2     = w_b9_out.q2;
        w_b10_in.c2     = w_b9_out.c2;
        w_b10_in.h2     = w_b9_out.h2;
        w_b10_in.hs2    = w_b9_out.hs2;
        w_b10_in.dc     = w_b9_out.dc;
        w_b10_in.newice = w_b9_out.newice;
        w_b10_in.clr    = (w_b9_out.c2 < w_cmin) || (w_b9_out.h2 < w_hmin);
    end
    sfm_mul u_mul_e (.i_clk, .i_en(w_en), .i_a(w_lfw), .i_b(sat_add(w_hr, w_sr)),
                     .o_p(w_e));
    sfm_dly #(.W($bits(t_b10)), .D(MUL_LAT)) u_dly10 (.i_clk, .i_en(w_en),
                     .i_d(w_b10_in), .o_q(w_b10_out));

    // Phase 11: heat returned per second on clearing
    sfm_div u_div_clr (.i_clk, .i_en(w_en), .i_a(w_e), .i_b(w_dt), .o_q(w_d9));
    sfm_dly #(.W($bits(t_b10)), .D(DIV_LAT)) u_dly11 (.i_clk, .i_en(w_en),
                     .i_d(w_b10_out), .o_q(w_b11_out));

    // Form the result, zeroing a cleared cell
    always_comb begin
        n_out.cleared = w_b11_out.clr;
        if (w_b11_out.clr) begin
            n_out.flux_out             = sat_add(w_b11_out.q2, w_d9);
            n_out.new_ice              = '0;
            n_out.concentration_out    = '0;
            n_out.ice_volume_out       = '0;
            n_out.snow_volume_out      = '0;
            n_out.concentration_change = sat_neg(w_b11_out.c2);
            n_out.removed_ice  = (w_b11_out.h2 > 0) ? -w_b11_out.h2 : '0;
            n_out.removed_snow = (w_b11_out.hs2 > 0) ? -w_b11_out.hs2 : '0;
        end else begin
            n_out.flux_out             = w_b11_out.q2;
            n_out.new_ice              = u63(w_b11_out.newice);
            n_out.concentration_out    = u63(w_b11_out.c2);
            n_out.ice_volume_out       = u63(w_b11_out.h2);
            n_out.snow_volume_out      = u63(w_b11_out.hs2);
            n_out.concentration_change = w_b11_out.dc;
            n_out.removed_ice          = '0;
            n_out.removed_snow         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfm_chk.sv =====
`default_nettype none

`include "sea_ice_freeze_melt_step_unit_assert.svh"

module sfm_chk import sfm_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_sfm_out o_out_data
);

    // Result stays offered until taken
    `SFM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // Offered result does not change while stalled
    `SFM_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data))

    // Input side never blocks while the output register is free
    `SFM_ASSERT_IMP(a_in_free, !o_out_valid || i_out_ready, o_in_ready)

    // A cleared cell reports no remaining ice, snow or concentration
    `SFM_ASSERT_IMP(a_clr_zero, o_out_valid && o_out_data.cleared,
        o_out_data.ice_volume_out == '0 && o_out_data.snow_volume_out == '0 && o_out_data.concentration_out == '0 && o_out_data.new_ice == '0)

    // Removed amounts appear only on a cleared cell
    `SFM_ASSERT_IMP(a_rem_only_clr, o_out_valid && !o_out_data.cleared,
        o_out_data.removed_ice == '0 && o_out_data.removed_snow == '0)

endmodule

bind sea_ice_freeze_melt_step_unit sfm_chk u_sfm_chk (.*);

`default_nettype wire

// ===== sim/sea_ice_freeze_melt_step_unit_test.sv =====
`default_nettype none

module sea_ice_freeze_melt_step_unit_test;
    import sfm_pkg::*;

    localparam int PIPE_DEPTH = 526;
    localparam t_s64 Q_TWO = 64'sh0000_0002_0000_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_sfm_in               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_sfm_out              o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sea_ice_freeze_melt_step_unit dut (.*);

    // Register shadow used by the cell predictor
    t_s64 h0_q, dt_q, cmin_q, hmin_q, lfi_q, lfw_q, rhoi_q, rhos_q;

    t_sfm_in  cell_queue[$];
    t_sfm_out result_queue[$];
    int       errors;
    int       send_idle_pct;
    int       recv_stall_pct;
    logic     send_hold;
    logic     in_taken;

    // Q32.32 multiply: magnitude truncated, saturated
    function automatic t_s64 qmul(input t_s64 a, input t_s64 b);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return from_mag(a[63] != b[63], p[127:96] != 0, p[95:32]);
    endfunction

    // Q32.32 divide: zero divisor gives zero
    function automatic t_s64 qdiv(input t_s64 a, input t_s64 b);
        logic [127:0] n;
        logic [127:0] qt;
        if (b == 0) return 0;
        n = {32'd0, mag(a), 32'd0};
        qt = n / {64'd0, mag(b)};
        return from_mag(a[63] != b[63], qt[127:64] != 0, qt[63:0]);
    endfunction

    function automatic t_sfm_out predict_cell(input t_sfm_in x);
        t_sfm_out r;
        t_s64 q, cap, t0, tf, c, h, hs, dhi;
        t_s64 dtml, t1, newice, dcm, dcf, dc, slice, sens, lat, hiold;
        t_s64 rem_i, rem_s;
        logic clr;
        q = x.open_water_flux;
        cap = {1'b0, x.heat_capacity};
        t0 = x.surface_temp;
        tf = x.freezing_temp;
        c = {31'd0, x.concentration};
        h = {1'b0, x.ice_volume};
        hs = {1'b0, x.snow_volume};
        dhi = x.thickness_change;
        newice = 0;
        dcm = 0;
        rem_i = 0;
        rem_s = 0;
        clr = 1'b0;
        dtml = qmul(qdiv(sat_neg(q), cap), dt_q);
        t1 = sat_add(t0, dtml);
        // Freeze when the mixed layer would drop below freezing
        if (t1 < tf) begin
            sens = qmul(qdiv(sat_sub(tf, t0), dtml), q);
            lat = sat_sub(q, sens);
            q = sens;
            newice = qdiv(qmul(qmul(lat, dt_q), sat_sub(Q_ONE, c)), qmul(lfi_q, rhoi_q));
            if (newice < 0) newice = 0;
        end
        // Lateral melt
        if (dhi < 0 && c > 0 && c < Q_ONE) begin
            hiold = sat_sub(qdiv(h, c), dhi);
            dcm = qdiv(qmul(dhi, c), qmul(Q_TWO, hiold));
        end
        dcf = qdiv(newice, h0_q);
        dc = sat_add(dcf, dcm);
        slice = qdiv(hs, (cmin_q > c) ? cmin_q : c);
        q = sat_sub(q, qdiv(qmul(qmul(qmul(dcm, slice), lfw_q), rhos_q), dt_q));
        hs = sat_add(hs, qmul(slice, dcm));
        c = sat_add(c, dc);
        h = sat_add(h, newice);
        // Clear cell below the minima
        if (c < cmin_q || h < hmin_q) begin
            q = sat_add(q, qdiv(qmul(lfw_q, sat_add(qmul(h, rhoi_q), qmul(hs, rhos_q))),
                                dt_q));
            dc = sat_neg(c);
            rem_i = (h > 0) ? -h : 0;
            rem_s = (hs > 0) ? -hs : 0;
            h = 0;
            c = 0;
            hs = 0;
            newice = 0;
            clr = 1'b1;
        end
        r.flux_out = q;
        r.new_ice = u63(newice);
        r.concentration_out = u63(c);
        r.ice_volume_out = u63(h);
        r.snow_volume_out = u63(hs);
        r.concentration_change = dc;
        r.cleared = clr;
        r.removed_ice = rem_i;
        r.removed_snow = rem_s;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: offer queued cells, hold each until transferred
    always @(negedge i_clk) begin
        if (i_in_valid && !in_taken) begin
            // hold until transferred
        end else if (cell_queue.size() > 0 && !send_hold && i_rst_n &&
                     $urandom_range(99) >= send_idle_pct) begin
            i_in_valid <= 1'b1;
            i_in_data <= cell_queue[0];
        end else begin
            i_in_valid <= 1'b0;
        end
        in_taken = 1'b0;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on input transfer, compare each result transfer
    always @(posedge i_clk) begin
        t_sfm_out exp_r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_queue.push_back(predict_cell(i_in_data));
            void'(cell_queue.pop_front());
            in_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                exp_r = result_queue.pop_front();
                if (exp_r !== o_out_data) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, o_out_data);
                    if (exp_r.flux_out !== o_out_data.flux_out)
                        $display("  flux_out expected %h actual %h",
                                 exp_r.flux_out, o_out_data.flux_out);
                    if (exp_r.new_ice !== o_out_data.new_ice)
                        $display("  new_ice expected %h actual %h",
                                 exp_r.new_ice, o_out_data.new_ice);
                    if (exp_r.concentration_out !== o_out_data.concentration_out)
                        $display("  concentration_out expected %h actual %h",
                                 exp_r.concentration_out, o_out_data.concentration_out);
                    if (exp_r.ice_volume_out !== o_out_data.ice_volume_out)
                        $display("  ice_volume_out expected %h actual %h",
                                 exp_r.ice_volume_out, o_out_data.ice_volume_out);
                    if (exp_r.snow_volume_out !== o_out_data.snow_volume_out)
                        $display("  snow_volume_out expected %h actual %h",
                                 exp_r.snow_volume_out, o_out_data.snow_volume_out);
                    if (exp_r.concentration_change !== o_out_data.concentration_change)
                        $display("  concentration_change expected %h actual %h",
                                 exp_r.concentration_change, o_out_data.concentration_change);
                    if (exp_r.cleared !== o_out_data.cleared)
                        $display("  cleared expected %b actual %b",
                                 exp_r.cleared, o_out_data.cleared);
                    if (exp_r.removed_ice !== o_out_data.removed_ice)
                        $display("  removed_ice expected %h actual %h",
                                 exp_r.removed_ice, o_out_data.removed_ice);
                    if (exp_r.removed_snow !== o_out_data.removed_snow)
                        $display("  removed_snow expected %h actual %h",
                                 exp_r.removed_snow, o_out_data.removed_snow);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value biased toward edges and physically sized numbers
    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            4: return {{24{$urandom_range(1) == 1}}, 8'($urandom), $urandom};
            default: return rand64();
        endcase
    endfunction

    function automatic t_sfm_in rand_cell();
        t_sfm_in x;
        logic [32:0] c;
        x = '0;
        case ($urandom_range(3))
            0: c = 33'h1_0000_0000;
            1: c = 33'($urandom_range(4));
            default: c = {$urandom_range(1) == 1, $urandom};
        endcase
        if ($urandom_range(3) != 0 && c > 33'h1_0000_0000) c = {1'b0, $urandom};
        x.concentration = c;
        if ($urandom_range(1) == 1) begin
            // Plausible cell: small magnitudes
            x.open_water_flux = $signed({{20{$urandom_range(1) == 1}}, 12'($urandom),
                                         $urandom});
            x.heat_capacity = {19'd0, 12'($urandom), $urandom};
            x.surface_temp = $signed({{28{$urandom_range(1) == 1}}, 4'($urandom), $urandom});
            x.freezing_temp = $signed({{28{$urandom_range(1) == 1}}, 4'($urandom), $urandom});
            x.ice_volume = {27'd0, 4'($urandom), $urandom};
            x.snow_volume = {27'd0, 4'($urandom), $urandom};
            x.thickness_change = $signed({{30{$urandom_range(1) == 1}}, 2'($urandom),
                                          $urandom});
        end else begin
            x.open_water_flux = pick64();
            x.heat_capacity = 63'(pick64());
            x.surface_temp = pick64();
            x.freezing_temp = pick64();
            x.ice_volume = 63'(pick64());
            x.snow_volume = 63'(pick64());
            x.thickness_change = pick64();
        end
        return x;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [62:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_H0:   h0_q = {1'b0, val};
            REG_DT:   dt_q = {1'b0, val};
            REG_CMIN: cmin_q = {31'd0, val[32:0]};
            REG_HMIN: hmin_q = {1'b0, val};
            REG_LFI:  lfi_q = {1'b0, val};
            REG_LFW:  lfw_q = {1'b0, val};
            REG_RHOI: rhoi_q = {1'b0, val};
            default:  rhos_q = {1'b0, val};
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || result_queue.size() > 0) @(negedge i_clk);
        repeat (PIPE_DEPTH / 50) @(negedge i_clk);
    endtask

    task automatic set_regs(input int mode);
        t_reg_idx r;
        for (int i = 0; i < 8; i++) begin
            r = t_reg_idx'(i);
            case (mode)
                0: write_reg(r, (r == REG_CMIN) ? 63'h1_0000_0000 : 63'h7FFF_FFFF_FFFF_FFFF);
                1: write_reg(r, (r == REG_HMIN) ? 63'd0 : 63'd1);
                default: write_reg(r, (r == REG_CMIN) ? 63'($urandom_range(1) ? $urandom : 1) :
                                      {27'd0, 4'($urandom), $urandom});
            endcase
        end
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) cell_queue.push_back(rand_cell());
        drain();
    endtask

    initial begin
        t_sfm_in x;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_hold = 1'b0;
        in_taken = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_H0;
        i_cfg_data = '0;
        h0_q = 64'sd1073741824;
        dt_q = 64'sd2576980377600;
        cmin_q = 64'sd1;
        hmin_q = 64'sd42949673;
        lfi_q = 64'sd1432586341580800;
        lfw_q = 64'sd1432586341580800;
        rhoi_q = 64'sd3938485010432;
        rhos_q = 64'sd1417339207680;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cells at reset settings: freeze, melt, clear, zero capacity, extremes
        x = '0;
        x.heat_capacity = 63'h1_0000_0000;
        x.surface_temp = -64'sh0000_0001_0000_0000;
        x.freezing_temp = -64'sh0000_0001_E000_0000;
        x.concentration = 33'h0_8000_0000;
        x.ice_volume = 63'h1_0000_0000;
        x.snow_volume = 63'h0_4000_0000;
        x.open_water_flux = 64'sh0000_00C8_0000_0000;
        cell_queue.push_back(x);
        x.thickness_change = -64'sh0000_0000_1000_0000;
        cell_queue.push_back(x);
        x.open_water_flux = 0;
        x.surface_temp = -64'sh0000_0003_0000_0000;
        cell_queue.push_back(x);
        x.heat_capacity = 0;
        cell_queue.push_back(x);
        x.concentration = 0;
        x.ice_volume = 0;
        cell_queue.push_back(x);
        x.concentration = 33'h1_0000_0000;
        x.ice_volume = '1;
        x.snow_volume = '1;
        cell_queue.push_back(x);
        x.open_water_flux = Q_MIN;
        x.surface_temp = Q_MIN;
        x.freezing_temp = Q_MAX;
        x.thickness_change = Q_MIN;
        x.heat_capacity = '1;
        cell_queue.push_back(x);
        x.concentration = 33'h1_FFFF_FFFF;
        x.open_water_flux = Q_MAX;
        x.surface_temp = Q_MAX;
        x.freezing_temp = Q_MIN;
        x.thickness_change = Q_MAX;
        cell_queue.push_back(x);
        x = '1;
        cell_queue.push_back(x);
        x = '0;
        cell_queue.push_back(x);
        for (int i = 0; i < 10; i++) cell_queue.push_back(rand_cell());
        drain();

        // Random phases across idle patterns and register settings
        run_phase(250, 0, 0);
        // Pause input until the pipeline is empty, then refill
        send_hold = 1'b1;
        for (int i = 0; i < 40; i++) cell_queue.push_back(rand_cell());
        while (result_queue.size() > 0) @(negedge i_clk);
        send_hold = 1'b0;
        drain();
        run_phase(250, 77, 0);
        set_regs(0);
        run_phase(150, 0, 77);
        set_regs(1);
        run_phase(150, 18, 18);
        set_regs(2);
        run_phase(250, 0, 0);
        set_regs(2);
        run_phase(200, 77, 77);
        set_regs(2);
        run_phase(250, 18, 18);

        repeat (PIPE_DEPTH + 20) @(negedge i_clk);
        if (errors == 0 && result_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/sfm_pkg.sv
design/sfm_dly.sv
design/sfm_mul.sv
design/sfm_div.sv
design/sea_ice_freeze_melt_step_unit.sv
design/sfm_chk.sv
sim/sea_ice_freeze_melt_step_unit_test.sv
